[sv/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants for the 16.16 fixed-point divider
// Holds the operand width, the saturation codes and the pipeline entry types.
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [DataW-1:0] SatPos   = 32'h7fff_ffff;
  localparam logic [DataW-1:0] SatNeg   = 32'h8000_0001;
  localparam logic [DataW-1:0] IntLimit = 32'h0000_8000;
  localparam logic [HalfW-1:0] FracMax  = 16'hffff;

  // Classified item handed from front to back
  typedef struct packed {
    logic [DataW-1:0] ua;
    logic [DataW-1:0] ub;
    logic             neg;
    logic             zero_div;
  } fpd_item_t;

  // Work carried down the integer stages
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [DataW-1:0] ub;
    logic [DataW-1:0] num;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [4:0]       k;
  } fpd_work_t;

  // Work carried down the fraction stages
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic             full;
    logic [HalfW-1:0] ip;
    logic [HalfW-1:0] dvs;
    logic [HalfW-1:0] prem;
    logic [HalfW-1:0] fnum;
    logic [HalfW-1:0] fq;
  } fpd_frac_t;

endpackage

[sv/fpd_front.sv]
// ----------------------------------------------------------------------------
// fpd_front: operand classification and hand-off queue
// Takes magnitudes and signs, flags a zero divisor, and queues the item.
// ----------------------------------------------------------------------------
module fpd_front #(
  parameter int unsigned Depth = fpd_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [fpd_pkg::DataW-1:0] dividend_i,
  input  logic [fpd_pkg::DataW-1:0] divisor_i,
  output logic                      item_vld_o,
  output fpd_pkg::fpd_item_t        item_o,
  input  logic                      item_rdy_i
);
  import fpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  fpd_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  fpd_item_t           cls;
  logic                push, pop;

  // Classify: magnitudes modulo 2^32, result sign, zero divisor
  always_comb begin
    cls.ua       = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
    cls.ub       = divisor_i[DataW-1]  ? (~divisor_i + 1'b1)  : divisor_i;
    cls.neg      = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    cls.zero_div = (divisor_i == '0);
  end

  assign busy_o     = (cnt_q == (PtrW+1)'(Depth));
  assign push       = start_i && !busy_o;
  assign item_vld_o = (cnt_q != '0);
  assign pop        = item_vld_o && item_rdy_i;
  assign item_o     = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

[sv/fpd_back.sv]
// ----------------------------------------------------------------------------
// fpd_back: pipelined restoring divider
// An entry register, one stage per integer quotient bit, a fraction set-up
// stage, one stage per fraction bit and a result register. Never stalls.
// ----------------------------------------------------------------------------
module fpd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_vld_i,
  input  fpd_pkg::fpd_item_t        item_i,
  output logic                      item_rdy_o,
  output logic                      res_vld_o,
  output logic [fpd_pkg::DataW-1:0] quotient_o,
  output logic                      saturated_o
);
  import fpd_pkg::*;

  localparam int unsigned IntSt  = DataW;
  localparam int unsigned FracSt = HalfW;

  fpd_work_t        st_q [IntSt+1];
  fpd_work_t        st_d [IntSt+1];
  logic [IntSt:0]   ivld_q;
  fpd_frac_t        fr_q [FracSt+1];
  fpd_frac_t        fr_d [FracSt+1];
  logic [FracSt:0]  fvld_q;
  fpd_frac_t        fin;
  logic [4:0]       k_in;
  logic [DataW-1:0] res_d, res_q;
  logic             sat_d, sat_q;
  logic             vld_q;

  assign item_rdy_o = 1'b1;

  // Bit length of the divisor high half (k)
  always_comb begin
    k_in = '0;
    for (int i = 0; i < HalfW; i++) begin
      if (item_i.ub[HalfW+i]) k_in = 5'(i + 1);
    end
  end

  // Load the entry stage, then integer long division, one bit per stage
  always_comb begin
    logic [DataW:0] trial, diff;
    st_d[0].neg = item_i.neg;
    st_d[0].sat = item_i.zero_div;
    st_d[0].ub  = item_i.ub;
    st_d[0].num = item_i.ua;
    st_d[0].rem = '0;
    st_d[0].quo = '0;
    st_d[0].k   = k_in;
    for (int s = 0; s < IntSt; s++) begin
      trial         = {st_q[s].rem, st_q[s].num[DataW-1]};
      diff          = trial - {1'b0, st_q[s].ub};
      st_d[s+1]     = st_q[s];
      st_d[s+1].num = {st_q[s].num[DataW-2:0], 1'b0};
      st_d[s+1].quo = {st_q[s].quo[DataW-2:0], ~diff[DataW]};
      st_d[s+1].rem = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
    end
  end

  // Set up the fraction divide: the divisor scaled down by k, and the
  // numerator (rem << (16-k)) whose top half is already below the divisor
  // unless the fraction is forced to its maximum
  always_comb begin
    logic [DataW-1:0] ubn, numf;
    logic [HalfW+1:0] trial, diff;
    ubn  = st_q[IntSt].ub >> st_q[IntSt].k;
    numf = st_q[IntSt].rem << (5'(HalfW) - st_q[IntSt].k);
    fr_d[0].neg  = st_q[IntSt].neg;
    fr_d[0].sat  = st_q[IntSt].sat || (st_q[IntSt].quo >= IntLimit);
    fr_d[0].full = (st_q[IntSt].rem >= (ubn << st_q[IntSt].k));
    fr_d[0].ip   = st_q[IntSt].quo[HalfW-1:0];
    fr_d[0].dvs  = ubn[HalfW-1:0];
    fr_d[0].prem = numf[DataW-1:HalfW];
    fr_d[0].fnum = numf[HalfW-1:0];
    fr_d[0].fq   = '0;
    // Fraction bits, one per stage over the low numerator half
    for (int s = 0; s < FracSt; s++) begin
      trial          = {1'b0, fr_q[s].prem, fr_q[s].fnum[HalfW-1]};
      diff           = trial - {2'b00, fr_q[s].dvs};
      fr_d[s+1]      = fr_q[s];
      fr_d[s+1].fnum = {fr_q[s].fnum[HalfW-2:0], 1'b0};
      fr_d[s+1].fq   = {fr_q[s].fq[HalfW-2:0], ~diff[HalfW+1]};
      fr_d[s+1].prem = diff[HalfW+1] ? trial[HalfW-1:0] : diff[HalfW-1:0];
    end
  end

  // Compose the result: saturate, clamp the fraction, apply the sign
  always_comb begin
    fin   = fr_q[FracSt];
    sat_d = fin.sat;
    if (fin.sat) begin
      res_d = fin.neg ? SatNeg : SatPos;
    end else begin
      res_d = {fin.ip, (fin.full ? FracMax : fin.fq)};
      if (fin.neg) res_d = ~res_d + 1'b1;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivld_q <= '0;
      fvld_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      ivld_q <= {ivld_q[IntSt-1:0], item_vld_i};
      fvld_q <= {fvld_q[FracSt-1:0], ivld_q[IntSt]};
      vld_q  <= fvld_q[FracSt];
    end
  end

  // Advance stage data
  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= IntSt; i++) st_q[i] <= st_d[i];
    for (int i = 0; i <= FracSt; i++) fr_q[i] <= fr_d[i];
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign res_vld_o   = vld_q;
  assign quotient_o  = res_q;
  assign saturated_o = sat_q;

endmodule

[sv/fixed_point_divide_q16_16.sv]
// Path: done_o rises after the queue entry, the entry register, 32 integer
// stages, the fraction set-up, 16 fraction stages and the result register.
// Throughput: one divide per cycle; busy never rises as the pipeline never stalls.
// Reset: asynchronous, active low; clears the queue and all valid bits.
// The receiver cannot stall; done_o marks each result for one cycle.
// ----------------------------------------------------------------------------
// fixed_point_divide_q16_16: signed 16.16 fixed-point divider
// Front classifies operands into a short queue; back divides in a pipeline.
// ----------------------------------------------------------------------------
module fixed_point_divide_q16_16 #(
  parameter int unsigned QueueDepth = fpd_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [fpd_pkg::DataW-1:0] dividend_i,
  input  logic [fpd_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [fpd_pkg::DataW-1:0] quotient_o,
  output logic                      saturated_o
);
  import fpd_pkg::*;

  fpd_item_t item;
  logic      item_vld, item_rdy;

  fpd_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .start_i    (start),
    .busy_o     (busy),
    .dividend_i,
    .divisor_i,
    .item_vld_o (item_vld),
    .item_o     (item),
    .item_rdy_i (item_rdy)
  );

  fpd_back u_back (
    .clk_i, .rst_ni,
    .item_vld_i  (item_vld),
    .item_i      (item),
    .item_rdy_o  (item_rdy),
    .res_vld_o   (done_o),
    .quotient_o,
    .saturated_o
  );

endmodule
